[hw/rtl/lts_pkg.sv]
// Package for the line tracking motor speed control block.
// Holds field widths, command and position codes, register indexes and reset values.
// No dependencies.
`default_nettype none

package lts_pkg;

    localparam int KIND_W  = 2;
    localparam int POS_W   = 3;
    localparam int SPEED_W = 10;
    localparam int ACC_W   = 12;
    localparam int TRIM_W  = 8;
    localparam int STEP_W  = 4;
    localparam int LIMIT_W = 11;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 11;

    localparam int FULL_SCALE = 1000;
    localparam int ACC_MAX    = 2047;
    localparam int ACC_MIN    = -15;

    typedef logic [KIND_W-1:0]         t_kind;
    typedef logic [POS_W-1:0]          t_pos;
    typedef logic [SPEED_W-1:0]        t_speed;
    typedef logic signed [ACC_W-1:0]   t_acc;
    typedef logic signed [TRIM_W-1:0]  t_trim;
    typedef logic [STEP_W-1:0]         t_step;
    typedef logic [LIMIT_W-1:0]        t_limit;
    typedef logic [CIDX_W-1:0]         t_cfg_idx;
    typedef logic [CDATA_W-1:0]        t_cfg_data;

    // command kinds
    localparam t_kind KIND_TICK    = 2'd0;
    localparam t_kind KIND_ENABLE  = 2'd1;
    localparam t_kind KIND_DISABLE = 2'd2;

    // line positions
    localparam t_pos POS_NONE      = 3'd0;
    localparam t_pos POS_LEFT      = 3'd1;
    localparam t_pos POS_RIGHT     = 3'd2;
    localparam t_pos POS_CENTER    = 3'd3;
    localparam t_pos POS_FAR_LEFT  = 3'd4;
    localparam t_pos POS_FAR_RIGHT = 3'd5;

    // register indexes
    localparam t_cfg_idx REG_AUTO_SPEED  = 3'd0;
    localparam t_cfg_idx REG_LEFT_TRIM   = 3'd1;
    localparam t_cfg_idx REG_RIGHT_TRIM  = 3'd2;
    localparam t_cfg_idx REG_MIN_SPEED   = 3'd3;
    localparam t_cfg_idx REG_STEER_GAIN  = 3'd4;
    localparam t_cfg_idx REG_RISE_STEP   = 3'd5;
    localparam t_cfg_idx REG_SETTLE_STEP = 3'd6;
    localparam t_cfg_idx REG_RISE_LIMIT  = 3'd7;

    // register reset values
    localparam t_speed RST_AUTO_SPEED  = 10'd1000;
    localparam t_trim  RST_LEFT_TRIM   = 8'sd0;
    localparam t_trim  RST_RIGHT_TRIM  = 8'sd0;
    localparam t_speed RST_MIN_SPEED   = 10'd0;
    localparam t_step  RST_STEER_GAIN  = 4'd2;
    localparam t_step  RST_RISE_STEP   = 4'd2;
    localparam t_step  RST_SETTLE_STEP = 4'd5;
    localparam t_limit RST_RISE_LIMIT  = 11'd1600;

endpackage

`default_nettype wire

[hw/rtl/lts_if.sv]
// Channel interfaces for the line tracking motor speed control block.
// Command input, result output and register write channels; depends on lts_pkg.
`default_nettype none

interface lts_in_if
    import lts_pkg::*;
();
    logic  valid;
    logic  ready;
    t_kind kind;
    logic  tracking_active;
    t_pos  line_position;

    modport source (output valid, kind, tracking_active, line_position, input ready);
    modport sink   (input valid, kind, tracking_active, line_position, output ready);
endinterface

interface lts_out_if
    import lts_pkg::*;
();
    logic   valid;
    logic   ready;
    t_speed left_compare;
    t_speed right_compare;
    logic   bridge_enable;
    t_acc   error_level;

    modport source (output valid, left_compare, right_compare, bridge_enable, error_level,
                    input ready);
    modport sink   (input valid, left_compare, right_compare, bridge_enable, error_level,
                    output ready);
endinterface

interface lts_cfg_if
    import lts_pkg::*;
();
    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/line_tracking_motor_speed_control.sv]
// Top level of the line tracking motor speed control block.
// Input register, steering update into the speed and accumulator registers, result valid.
// Depends on lts_pkg and the channel interfaces in lts_if.sv.
//
//  channel  | dir | payload                                                   | handshake
//  ---------+-----+-----------------------------------------------------------+-----------
//  i_in     | in  | kind, tracking_active, line_position                      | valid/ready
//  o_out    | out | left_compare, right_compare, bridge_enable, error_level   | valid/ready
//  i_cfg    | in  | index, data                                               | valid/ready
//
// One word per cycle sustained while o_out.ready holds high. An accepted word waits in the
// input register, which feeds one pass of update logic (accumulator add, gain multiply,
// clamps) that loads the state registers, which double as the result register, and sets result valid.
// While a result waits on o_out.ready the input register still takes one more word.
// Reset (synchronous, active low) zeroes speeds, accumulator and bridge flag and loads
// the register defaults. Register writes are always ready.
`default_nettype none

module line_tracking_motor_speed_control
    import lts_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    lts_in_if.sink   i_in,
    lts_out_if.source o_out,
    lts_cfg_if.sink  i_cfg
);

    // configuration registers
    t_speed r_auto_speed;
    t_trim  r_left_trim;
    t_trim  r_right_trim;
    t_speed r_min_speed;
    t_step  r_steer_gain;
    t_step  r_rise_step;
    t_step  r_settle_step;
    t_limit r_rise_limit;

    // input register
    logic  r_in_valid;
    t_kind r_in_kind;
    logic  r_in_active;
    t_pos  r_in_pos;

    // state, also the result payload
    t_acc   r_error_accum;
    t_speed r_left_speed;
    t_speed r_right_speed;
    logic   r_bridge_on;
    logic   r_out_valid;

    t_acc   n_error_accum;
    t_speed n_left_speed;
    t_speed n_right_speed;
    logic   n_bridge_on;

    logic w_adv;
    logic w_in_take;

    logic signed [ACC_W:0]   w_grow;
    t_acc                    w_acc_grown;
    logic signed [ACC_W-1:0] w_left_base;
    logic signed [ACC_W-1:0] w_right_base;
    logic signed [16:0]      w_prod;
    logic signed [16:0]      w_far_left;
    logic signed [16:0]      w_far_right;

    function automatic t_speed clamp_full(input logic signed [ACC_W-1:0] v);
        t_speed res;
        if (v < 0) begin
            res = '0;
        end else if (v > ACC_W'(FULL_SCALE)) begin
            res = SPEED_W'(FULL_SCALE);
        end else begin
            res = v[SPEED_W-1:0];
        end
        return res;
    endfunction

    function automatic t_speed clamp_far(input logic signed [16:0] v, input t_speed lo);
        logic signed [16:0] t;
        t = v;
        if (t < $signed({7'd0, lo})) begin
            t = $signed({7'd0, lo});
        end
        if (t > 17'(FULL_SCALE)) begin
            t = 17'(FULL_SCALE);
        end
        return t[SPEED_W-1:0];
    endfunction

    // advance when the result slot is free or being emptied
    assign w_adv     = r_in_valid && (!r_out_valid || o_out.ready);
    assign w_in_take = i_in.valid && i_in.ready;

    assign i_in.ready  = !r_in_valid || w_adv;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid         = r_out_valid;
    assign o_out.left_compare  = r_left_speed;
    assign o_out.right_compare = r_right_speed;
    assign o_out.bridge_enable = r_bridge_on;
    assign o_out.error_level   = r_error_accum;

    // accumulator growth, saturating at the top
    always_comb begin
        w_grow = $signed({r_error_accum[ACC_W-1], r_error_accum}) +
                 $signed({{(ACC_W-STEP_W+1){1'b0}}, r_rise_step});
        if (r_error_accum < $signed({1'b0, r_rise_limit})) begin
            if (w_grow > (ACC_W+1)'(ACC_MAX)) begin
                w_acc_grown = ACC_W'(ACC_MAX);
            end else begin
                w_acc_grown = w_grow[ACC_W-1:0];
            end
        end else begin
            w_acc_grown = r_error_accum;
        end
    end

    assign w_left_base  = $signed({2'b00, r_auto_speed}) + ACC_W'(r_left_trim);
    assign w_right_base = $signed({2'b00, r_auto_speed}) + ACC_W'(r_right_trim);

    assign w_prod      = 17'(w_acc_grown) * $signed({13'd0, r_steer_gain});
    assign w_far_left  = $signed({7'd0, r_left_speed}) - w_prod;
    assign w_far_right = $signed({7'd0, r_right_speed}) - w_prod;

    always_comb begin
        n_error_accum = r_error_accum;
        n_left_speed  = r_left_speed;
        n_right_speed = r_right_speed;
        n_bridge_on   = r_bridge_on;
        case (r_in_kind)
            KIND_TICK: begin
                if (r_in_active) begin
                    n_error_accum = w_acc_grown;
                    if (r_in_pos inside {POS_LEFT, POS_RIGHT, POS_CENTER}) begin
                        n_left_speed  = clamp_full(w_left_base);
                        n_right_speed = clamp_full(w_right_base);
                        if (w_acc_grown > 0) begin
                            n_error_accum = w_acc_grown - $signed({8'd0, r_settle_step});
                        end
                    end else if (r_in_pos == POS_FAR_LEFT) begin
                        n_left_speed = clamp_far(w_far_left, r_min_speed);
                    end else if (r_in_pos == POS_FAR_RIGHT) begin
                        n_right_speed = clamp_far(w_far_right, r_min_speed);
                    end
                end
            end
            KIND_ENABLE, KIND_DISABLE: begin
                n_left_speed  = '0;
                n_right_speed = '0;
                n_bridge_on   = (r_in_kind == KIND_ENABLE);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_speed  <= RST_AUTO_SPEED;
            r_left_trim   <= RST_LEFT_TRIM;
            r_right_trim  <= RST_RIGHT_TRIM;
            r_min_speed   <= RST_MIN_SPEED;
            r_steer_gain  <= RST_STEER_GAIN;
            r_rise_step   <= RST_RISE_STEP;
            r_settle_step <= RST_SETTLE_STEP;
            r_rise_limit  <= RST_RISE_LIMIT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_AUTO_SPEED:  r_auto_speed  <= i_cfg.data[SPEED_W-1:0];
                REG_LEFT_TRIM:   r_left_trim   <= $signed(i_cfg.data[TRIM_W-1:0]);
                REG_RIGHT_TRIM:  r_right_trim  <= $signed(i_cfg.data[TRIM_W-1:0]);
                REG_MIN_SPEED:   r_min_speed   <= i_cfg.data[SPEED_W-1:0];
                REG_STEER_GAIN:  r_steer_gain  <= i_cfg.data[STEP_W-1:0];
                REG_RISE_STEP:   r_rise_step   <= i_cfg.data[STEP_W-1:0];
                REG_SETTLE_STEP: r_settle_step <= i_cfg.data[STEP_W-1:0];
                REG_RISE_LIMIT:  r_rise_limit  <= i_cfg.data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    // hold the word until it moves on
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_kind   <= i_in.kind;
            r_in_active <= i_in.tracking_active;
            r_in_pos    <= i_in.line_position;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_accum <= '0;
            r_left_speed  <= '0;
            r_right_speed <= '0;
            r_bridge_on   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_adv) begin
                r_error_accum <= n_error_accum;
                r_left_speed  <= n_left_speed;
                r_right_speed <= n_right_speed;
                r_bridge_on   <= n_bridge_on;
                r_out_valid   <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_acc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_error_accum >= ACC_W'(ACC_MIN)) && (r_error_accum <= ACC_W'(ACC_MAX)))
        else $error("accumulator out of range");

    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left_speed <= SPEED_W'(FULL_SCALE)) && (r_right_speed <= SPEED_W'(FULL_SCALE)))
        else $error("speed above full scale");

    a_bridge_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && (r_in_kind == KIND_ENABLE || r_in_kind == KIND_DISABLE) |=>
        r_left_speed == '0 && r_right_speed == '0 &&
        r_bridge_on == $past(r_in_kind == KIND_ENABLE))
        else $error("bridge command did not stop motors");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_error_accum) && $stable(r_left_speed) &&
        $stable(r_right_speed) && $stable(r_bridge_on))
        else $error("state changed without an advancing word");

    a_slot_guard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |-> !w_adv)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for line_tracking_motor_speed_control: a directed script, then
// randomized steering phases with random or extreme settings and random handshake pacing.
// Depends on lts_pkg, the lts_*_if interfaces and the block's RTL.

module testbench;
    import lts_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 12;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int TAIL_CYCLES     = 10;
    localparam int NUM_PHASES      = 10;
    localparam int WINDUP_ITEMS    = 170;
    localparam int PHASE_ITEMS     = 80;
    localparam int PRESSURE_PHASE  = 5;
    localparam int DIRECTED_COUNT  = 24;
    localparam int DIRECTED_SPLIT  = 20;

    // codes the block must ignore or treat as no line
    localparam t_kind KIND_SPARE  = 2'd3;
    localparam t_pos  POS_SPARE_A = 3'd6;
    localparam t_pos  POS_SPARE_B = 3'd7;

    typedef enum int {PACE_NONE, PACE_FULL, PACE_RARE} t_pace;
    typedef enum int {MIX_RANDOM, MIX_ALL_LOW, MIX_ALL_HIGH, MIX_WINDUP} t_setting_style;

    typedef struct packed {
        t_speed left_cmp;
        t_speed right_cmp;
        logic   bridge;
        t_acc   level;
    } t_motor_result;

    typedef struct packed {
        t_kind         kind;
        logic          active;
        t_pos          pos;
        logic          pinned;
        t_motor_result want;
    } t_script_row;

    localparam t_motor_result UNPINNED = '0;

    localparam t_script_row DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{KIND_SPARE,   1'b1, POS_CENTER,    1'b1, '{10'd0,    10'd0,    1'b0, 12'sd0}},
        '{KIND_TICK,    1'b0, POS_CENTER,    1'b1, '{10'd0,    10'd0,    1'b0, 12'sd0}},
        '{KIND_ENABLE,  1'b1, POS_NONE,      1'b1, '{10'd0,    10'd0,    1'b1, 12'sd0}},
        '{KIND_TICK,    1'b1, POS_NONE,      1'b1, '{10'd0,    10'd0,    1'b1, 12'sd2}},
        '{KIND_TICK,    1'b1, POS_CENTER,    1'b1, '{10'd1000, 10'd1000, 1'b1, -12'sd1}},
        '{KIND_TICK,    1'b1, POS_CENTER,    1'b1, '{10'd1000, 10'd1000, 1'b1, -12'sd4}},
        '{KIND_TICK,    1'b1, POS_FAR_LEFT,  1'b1, '{10'd1000, 10'd1000, 1'b1, -12'sd2}},
        '{KIND_TICK,    1'b1, POS_NONE,      1'b1, '{10'd1000, 10'd1000, 1'b1, 12'sd0}},
        '{KIND_TICK,    1'b1, POS_NONE,      1'b1, '{10'd1000, 10'd1000, 1'b1, 12'sd2}},
        '{KIND_TICK,    1'b1, POS_FAR_RIGHT, 1'b1, '{10'd1000, 10'd992,  1'b1, 12'sd4}},
        '{KIND_TICK,    1'b1, POS_SPARE_A,   1'b1, '{10'd1000, 10'd992,  1'b1, 12'sd6}},
        '{KIND_TICK,    1'b1, POS_SPARE_B,   1'b1, '{10'd1000, 10'd992,  1'b1, 12'sd8}},
        '{KIND_TICK,    1'b1, POS_FAR_LEFT,  1'b1, '{10'd980,  10'd992,  1'b1, 12'sd10}},
        '{KIND_TICK,    1'b1, POS_LEFT,      1'b1, '{10'd1000, 10'd1000, 1'b1, 12'sd7}},
        '{KIND_TICK,    1'b1, POS_RIGHT,     1'b1, '{10'd1000, 10'd1000, 1'b1, 12'sd4}},
        '{KIND_DISABLE, 1'b1, POS_NONE,      1'b1, '{10'd0,    10'd0,    1'b0, 12'sd4}},
        '{KIND_TICK,    1'b0, POS_FAR_LEFT,  1'b1, '{10'd0,    10'd0,    1'b0, 12'sd4}},
        '{KIND_SPARE,   1'b1, POS_FAR_RIGHT, 1'b1, '{10'd0,    10'd0,    1'b0, 12'sd4}},
        '{KIND_ENABLE,  1'b0, POS_NONE,      1'b1, '{10'd0,    10'd0,    1'b1, 12'sd4}},
        '{KIND_TICK,    1'b1, POS_FAR_LEFT,  1'b1, '{10'd0,    10'd0,    1'b1, 12'sd6}},
        // under the high extreme settings: base clamp, far cut against the minimum
        '{KIND_ENABLE,  1'b1, POS_NONE,      1'b0, UNPINNED},
        '{KIND_TICK,    1'b1, POS_CENTER,    1'b0, UNPINNED},
        '{KIND_TICK,    1'b1, POS_FAR_RIGHT, 1'b0, UNPINNED},
        '{KIND_TICK,    1'b1, POS_FAR_LEFT,  1'b0, UNPINNED}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    lts_in_if  in_ch ();
    lts_out_if out_ch ();
    lts_cfg_if cfg_ch ();

    line_tracking_motor_speed_control dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // shadow settings and steering state
    t_speed set_auto;
    t_trim  set_left_trim;
    t_trim  set_right_trim;
    t_speed set_min;
    t_step  set_gain;
    t_step  set_rise;
    t_step  set_settle;
    t_limit set_limit;
    int     accum_now;
    int     left_now;
    int     right_now;
    logic   bridge_now;

    t_motor_result expected_results [$];
    t_pace         sender_mode;
    t_pace         sink_mode;
    int            fail_count;
    int            words_sent;
    int            results_checked;
    int            peak_level;
    int            floor_level;
    int            quiet_cycles;

    function automatic int clamp_scale(int v);
        if (v < 0) return 0;
        if (v > FULL_SCALE) return FULL_SCALE;
        return v;
    endfunction

    function automatic int far_cut(int speed);
        int v;
        v = speed - accum_now * int'(set_gain);
        if (v < int'(set_min)) v = int'(set_min);
        if (v > FULL_SCALE) v = FULL_SCALE;
        return v;
    endfunction

    function automatic t_motor_result steer_update(t_kind k, logic act, t_pos p);
        t_motor_result r;
        if (k == KIND_TICK && act) begin
            if (accum_now < int'(set_limit)) begin
                accum_now += int'(set_rise);
                if (accum_now > ACC_MAX) accum_now = ACC_MAX;
            end
            if (p == POS_LEFT || p == POS_RIGHT || p == POS_CENTER) begin
                left_now  = clamp_scale(int'(set_auto) + int'(set_left_trim));
                right_now = clamp_scale(int'(set_auto) + int'(set_right_trim));
                if (accum_now > 0) accum_now -= int'(set_settle);
            end else if (p == POS_FAR_LEFT) begin
                left_now = far_cut(left_now);
            end else if (p == POS_FAR_RIGHT) begin
                right_now = far_cut(right_now);
            end
        end else if (k == KIND_ENABLE || k == KIND_DISABLE) begin
            left_now   = 0;
            right_now  = 0;
            bridge_now = (k == KIND_ENABLE);
        end
        r.left_cmp  = t_speed'(left_now);
        r.right_cmp = t_speed'(right_now);
        r.bridge    = bridge_now;
        r.level     = t_acc'(accum_now);
        return r;
    endfunction

    function automatic void load_register(t_cfg_idx idx, t_cfg_data d);
        case (idx)
            REG_AUTO_SPEED:  set_auto       = d[SPEED_W-1:0];
            REG_LEFT_TRIM:   set_left_trim  = d[TRIM_W-1:0];
            REG_RIGHT_TRIM:  set_right_trim = d[TRIM_W-1:0];
            REG_MIN_SPEED:   set_min        = d[SPEED_W-1:0];
            REG_STEER_GAIN:  set_gain       = d[STEP_W-1:0];
            REG_RISE_STEP:   set_rise       = d[STEP_W-1:0];
            REG_SETTLE_STEP: set_settle     = d[STEP_W-1:0];
            REG_RISE_LIMIT:  set_limit      = d[LIMIT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic int draw_gap(t_pace mode);
        case (mode)
            PACE_FULL: return $urandom_range(0, 15);
            PACE_RARE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
            default:   return 0;
        endcase
    endfunction

    function automatic int pick_value(int lo, int hi);
        case ($urandom_range(0, 5))
            0:       return lo;
            1:       return hi;
            default: return lo + int'($urandom_range(0, hi - lo));
        endcase
    endfunction

    // put the value in the low bits and random junk above the register width
    function automatic t_cfg_data with_noise(int value, int width);
        int junk;
        junk = $urandom_range(0, (1 << (CDATA_W - width)) - 1);
        return t_cfg_data'((junk << width) | (value & ((1 << width) - 1)));
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // leave valid high on return; a drain lowers it, the next call only when it draws a gap
    task automatic send_word(t_kind k, logic act, t_pos p, logic pinned, t_motor_result pin);
        int            gap;
        t_motor_result predicted;
        gap = draw_gap(sender_mode);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.kind            <= k;
        in_ch.tracking_active <= act;
        in_ch.line_position   <= p;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        predicted = steer_update(k, act, p);
        expected_results.push_back(pinned ? pin : predicted);
        words_sent++;
    endtask

    task automatic send_random_word(int center_pct);
        int    roll;
        t_kind k;
        logic  act;
        t_pos  p;
        roll = $urandom_range(0, 99);
        if (roll < 3)       k = KIND_SPARE;
        else if (roll < 7)  k = KIND_ENABLE;
        else if (roll < 10) k = KIND_DISABLE;
        else                k = KIND_TICK;
        act  = ($urandom_range(0, 11) != 0);
        roll = $urandom_range(0, 99);
        if (roll < center_pct) begin
            p = t_pos'($urandom_range(POS_LEFT, POS_CENTER));
        end else begin
            roll = $urandom_range(0, 9);
            if (roll < 6)      p = t_pos'($urandom_range(POS_FAR_LEFT, POS_FAR_RIGHT));
            else if (roll < 9) p = POS_NONE;
            else               p = t_pos'($urandom_range(POS_SPARE_A, POS_SPARE_B));
        end
        send_word(k, act, p, 1'b0, UNPINNED);
    endtask

    // hold the input and wait for every outstanding result
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic write_register(t_cfg_idx idx, t_cfg_data d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        load_register(idx, d);
    endtask

    task automatic program_registers(int auto_v, int ltrim, int rtrim, int min_v,
                                     int gain, int rise, int settle, int limit);
        write_register(REG_AUTO_SPEED,  with_noise(auto_v, SPEED_W));
        write_register(REG_LEFT_TRIM,   with_noise(ltrim, TRIM_W));
        write_register(REG_RIGHT_TRIM,  with_noise(rtrim, TRIM_W));
        write_register(REG_MIN_SPEED,   with_noise(min_v, SPEED_W));
        write_register(REG_STEER_GAIN,  with_noise(gain, STEP_W));
        write_register(REG_RISE_STEP,   with_noise(rise, STEP_W));
        write_register(REG_SETTLE_STEP, with_noise(settle, STEP_W));
        write_register(REG_RISE_LIMIT,  with_noise(limit, LIMIT_W));
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic program_style(t_setting_style style);
        int min_v;
        min_v = ($urandom_range(0, 3) == 0) ? pick_value(0, 1023) : pick_value(0, 300);
        case (style)
            MIX_ALL_LOW:  program_registers(0, -128, -128, 0, 0, 0, 0, 0);
            MIX_ALL_HIGH: program_registers(1023, 127, 127, 1023, 15, 15, 15, 2047);
            MIX_WINDUP:   program_registers(pick_value(0, 1023), pick_value(-128, 127),
                                            pick_value(-128, 127), min_v, pick_value(0, 15),
                                            15, pick_value(0, 15), 2047);
            default:      program_registers(pick_value(0, 1023), pick_value(-128, 127),
                                            pick_value(-128, 127), min_v, pick_value(0, 15),
                                            pick_value(0, 15), pick_value(0, 15),
                                            pick_value(0, 2047));
        endcase
    endtask

    always @(posedge i_clk) begin : result_check
        t_motor_result want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (expected_results.size() == 0) begin
                $error("result word with nothing expected: left %0d right %0d level %0d",
                       out_ch.left_compare, out_ch.right_compare, out_ch.error_level);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("left_compare", want.left_cmp, out_ch.left_compare);
                check_field("right_compare", want.right_cmp, out_ch.right_compare);
                check_field("bridge_enable", want.bridge, out_ch.bridge_enable);
                check_field("error_level", int'(want.level), int'(out_ch.error_level));
                results_checked++;
            end
            if (int'(out_ch.error_level) > peak_level)  peak_level  = int'(out_ch.error_level);
            if (int'(out_ch.error_level) < floor_level) floor_level = int'(out_ch.error_level);
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("line_tracking_motor_speed_control verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : result_pacing
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = draw_gap(sink_mode);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
        end
    end

    initial begin : stimulus
        int             ph;
        int             n;
        int             count;
        int             center_pct;
        t_setting_style style;

        i_rst_n               = 1'b0;
        in_ch.valid           = 1'b0;
        in_ch.kind            = KIND_TICK;
        in_ch.tracking_active = 1'b0;
        in_ch.line_position   = POS_NONE;
        out_ch.ready          = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = REG_AUTO_SPEED;
        cfg_ch.data           = '0;
        fail_count      = 0;
        words_sent      = 0;
        results_checked = 0;
        peak_level      = 0;
        floor_level     = 0;
        quiet_cycles    = 0;
        sender_mode     = PACE_FULL;
        sink_mode       = PACE_FULL;

        set_auto       = RST_AUTO_SPEED;
        set_left_trim  = RST_LEFT_TRIM;
        set_right_trim = RST_RIGHT_TRIM;
        set_min        = RST_MIN_SPEED;
        set_gain       = RST_STEER_GAIN;
        set_rise       = RST_RISE_STEP;
        set_settle     = RST_SETTLE_STEP;
        set_limit      = RST_RISE_LIMIT;
        accum_now      = 0;
        left_now       = 0;
        right_now      = 0;
        bridge_now     = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < DIRECTED_COUNT; n++) begin
            if (n == DIRECTED_SPLIT) begin
                drain_results();
                program_style(MIX_ALL_HIGH);
            end
            send_word(DIRECTED_ROWS[n].kind, DIRECTED_ROWS[n].active, DIRECTED_ROWS[n].pos,
                      DIRECTED_ROWS[n].pinned, DIRECTED_ROWS[n].want);
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            case (ph)
                0:       style = MIX_WINDUP;
                1:       style = MIX_ALL_LOW;
                2:       style = MIX_ALL_HIGH;
                default: style = MIX_RANDOM;
            endcase
            program_style(style);
            sender_mode = t_pace'(ph % 3);
            sink_mode   = t_pace'($urandom_range(0, 2));
            // the windup phase avoids the center so the accumulator reaches its ceiling
            center_pct  = (ph == 0) ? 0 : 10 + 30 * $urandom_range(0, 2);
            count       = (ph == 0) ? WINDUP_ITEMS : PHASE_ITEMS;
            send_word(KIND_ENABLE, 1'b1, POS_NONE, 1'b0, UNPINNED);
            send_word(KIND_TICK, 1'b1, POS_CENTER, 1'b0, UNPINNED);
            for (n = 0; n < count; n++) begin
                if (ph == PRESSURE_PHASE && n == count / 2) drain_results();
                send_random_word(center_pct);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d command words over %0d setting phases, %0d results checked",
                 words_sent, NUM_PHASES + 2, results_checked);
        $display("accumulator seen from %0d up to %0d", floor_level, peak_level);
        if (fail_count == 0) begin
            $display("line_tracking_motor_speed_control verification clean");
        end else begin
            $display("line_tracking_motor_speed_control verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/lts_pkg.sv
hw/rtl/lts_if.sv
hw/rtl/line_tracking_motor_speed_control.sv
sim/testbench.sv
